// ===== design/cbpm_pkg.sv =====
// Package for the brake pedal monitor: widths, codes, register indexes and
// the structs shared by the front, queue, back and top level. No dependencies.
package cbpm_pkg;

    localparam int LOST_COUNT_MAX = 255;
    localparam int LOST_W         = $clog2(LOST_COUNT_MAX + 1);

    localparam int ID_W       = 29;
    localparam int LEVEL_W    = 8;
    localparam int REGEN_W    = 7;
    localparam int STATUS_W   = 2;
    localparam int POS_W      = 10;
    localparam int REGEN_OUT_W = 12;
    localparam int LOST_CMP_W = (LOST_W > LEVEL_W) ? LOST_W : LEVEL_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = ID_W;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = ((ID_W + LEVEL_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((STATUS_W + 1 + POS_W + REGEN_OUT_W + 7) / 8) * 8;

    localparam logic [POS_W-1:0] POS_FULL = POS_W'(1000);

    // divider retires two quotient bits per step
    localparam int DIV_STEPS = POS_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // floor(a / 100) = (a * RECIP_100) >> RECIP_SHIFT for a below 2^17
    localparam int PROD_W      = REGEN_W + POS_W;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = 18;
    localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(167773);
    localparam int SCALED_W    = 11;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RESPONSE_ID = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LOST    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_REGEN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_REGEN   = 3'd6;

    localparam logic ACT_TICK = 1'b0;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_LOST = 2'd1,
        ST_HIGH = 2'd2,
        ST_LOW  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_MUL,
        BK_SCALE,
        BK_DONE
    } t_back_state;

    typedef struct packed {
        logic [ID_W-1:0]    response_id;
        logic [LEVEL_W-1:0] min_level;
        logic [LEVEL_W-1:0] max_level;
        logic [LEVEL_W-1:0] tolerance;
        logic [LEVEL_W-1:0] max_lost;
        logic [REGEN_W-1:0] min_regen;
        logic [REGEN_W-1:0] max_regen;
    } t_cfg;

    // classified item passed from front to back
    typedef struct packed {
        t_status            status;
        logic [LEVEL_W-1:0] raw;
    } t_item;

endpackage

// ===== design/can_brake_pedal_monitor.sv =====
// Top level of the brake pedal monitor: configuration registers, front,
// queue and back. Depends on cbpm_pkg, cbpm_front, cbpm_queue and cbpm_back.
//
//  channel   | signals                        | payload
//  ----------+--------------------------------+------------------------------------
//  input     | s_axis_tvalid / s_axis_tready  | tuser: action; tdata: frame_id, position_byte
//  result    | m_axis_tvalid / m_axis_tready  | tdata: status, signal_valid, position, regen
//  config    | i_cfg_we, i_cfg_idx            | i_cfg_data, no read-back
//
// The front classifies a transaction as it is accepted and parks it in a two-entry queue.
// The back steps through idle, multiply, scale and done for each result, with the
// position divider (5 steps of two quotient bits each) between idle and multiply when it runs.
// Reset is synchronous and active low; registers return to their defaults.
// A stalled result port fills the queue, after which s_axis_tready drops.
module can_brake_pedal_monitor (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [cbpm_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // frame_id, position_byte
    input  logic                              s_axis_tuser,  // action
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // status, signal_valid, pedal_position, regen_level
    output logic [cbpm_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [cbpm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cbpm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import cbpm_pkg::*;

    t_cfg  r_cfg;
    t_item w_front_item, w_queue_item;
    logic  w_push, w_pop, w_full, w_empty;

    logic [STATUS_W-1:0]           w_status;
    logic                          w_signal_valid;
    logic [POS_W-1:0]              w_pos;
    logic signed [REGEN_OUT_W-1:0] w_regen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.response_id <= ID_W'(1896);
            r_cfg.min_level   <= '0;
            r_cfg.max_level   <= '0;
            r_cfg.tolerance   <= LEVEL_W'(10);
            r_cfg.max_lost    <= LEVEL_W'(3);
            r_cfg.min_regen   <= '0;
            r_cfg.max_regen   <= REGEN_W'(50);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RESPONSE_ID: r_cfg.response_id <= i_cfg_data;
                REG_MIN_LEVEL:   r_cfg.min_level   <= i_cfg_data[LEVEL_W-1:0];
                REG_MAX_LEVEL:   r_cfg.max_level   <= i_cfg_data[LEVEL_W-1:0];
                REG_TOLERANCE:   r_cfg.tolerance   <= i_cfg_data[LEVEL_W-1:0];
                REG_MAX_LOST:    r_cfg.max_lost    <= i_cfg_data[LEVEL_W-1:0];
                REG_MIN_REGEN:   r_cfg.min_regen   <= i_cfg_data[REGEN_W-1:0];
                REG_MAX_REGEN:   r_cfg.max_regen   <= i_cfg_data[REGEN_W-1:0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    cbpm_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_valid         (s_axis_tvalid),
        .o_ready         (s_axis_tready),
        .i_action        (s_axis_tuser),
        .i_frame_id      (s_axis_tdata[ID_W-1:0]),
        .i_position_byte (s_axis_tdata[ID_W +: LEVEL_W]),
        .i_q_full        (w_full),
        .o_push          (w_push),
        .o_item          (w_front_item)
    );

    cbpm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_item  (w_queue_item),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    cbpm_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_q_empty        (w_empty),
        .i_item           (w_queue_item),
        .o_pop            (w_pop),
        .o_valid          (m_axis_tvalid),
        .i_ready          (m_axis_tready),
        .o_status         (w_status),
        .o_signal_valid   (w_signal_valid),
        .o_pedal_position (w_pos),
        .o_regen_level    (w_regen)
    );

    assign m_axis_tdata = M_TDATA_W'({w_regen, w_pos, w_signal_valid, w_status});

endmodule

// ===== design/cbpm_front.sv =====
// Front of the brake pedal monitor: accepts ticks and frames, keeps the
// lost-response counter and raw reading, and classifies the status. Uses cbpm_pkg.
module cbpm_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cbpm_pkg::t_cfg                i_cfg,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_action,
    input  logic [cbpm_pkg::ID_W-1:0]     i_frame_id,
    input  logic [cbpm_pkg::LEVEL_W-1:0]  i_position_byte,
    input  logic                          i_q_full,
    output logic                          o_push,
    output cbpm_pkg::t_item               o_item
);
    import cbpm_pkg::*;

    logic [LOST_W-1:0]  r_lost_ticks, n_lost_ticks;
    logic [LEVEL_W-1:0] r_raw, n_raw;
    logic               w_accept;
    logic               w_lost, w_high, w_low;

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;
    assign o_push   = w_accept;

    always_comb begin
        n_lost_ticks = r_lost_ticks;
        n_raw        = r_raw;
        if (i_action == ACT_TICK) begin
            if (r_lost_ticks != LOST_W'(LOST_COUNT_MAX)) begin
                n_lost_ticks = r_lost_ticks + 1'b1;
            end
        end else if (i_frame_id == i_cfg.response_id) begin
            n_raw        = i_position_byte;
            n_lost_ticks = '0;
        end
    end

    // classify against the state as it stands after this transaction
    assign w_lost = LOST_CMP_W'(n_lost_ticks) >= LOST_CMP_W'(i_cfg.max_lost);
    assign w_high = {1'b0, n_raw} > ({1'b0, i_cfg.max_level} + {1'b0, i_cfg.tolerance});
    assign w_low  = ({1'b0, n_raw} + {1'b0, i_cfg.tolerance}) < {1'b0, i_cfg.min_level};

    always_comb begin
        o_item.raw = n_raw;
        priority if (w_lost) begin
            o_item.status = ST_LOST;
        end else if (w_high) begin
            o_item.status = ST_HIGH;
        end else if (w_low) begin
            o_item.status = ST_LOW;
        end else begin
            o_item.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lost_ticks <= LOST_W'(LOST_COUNT_MAX);
            r_raw        <= '0;
        end else if (w_accept) begin
            r_lost_ticks <= n_lost_ticks;
            r_raw        <= n_raw;
        end
    end

endmodule

// ===== design/cbpm_queue.sv =====
// Two-entry queue between front and back of the brake pedal monitor.
// Carries classified items; uses cbpm_pkg.
module cbpm_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cbpm_pkg::t_item i_item,
    input  logic            i_pop,
    output cbpm_pkg::t_item o_item,
    output logic            o_full,
    output logic            o_empty
);
    import cbpm_pkg::*;

    t_item      r_entry [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_item  = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== design/cbpm_back.sv =====
// Back of the brake pedal monitor: normalises the raw reading with a
// two-bit-per-step divider, scales the regen request and holds the result.
// Uses cbpm_pkg.
module cbpm_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cbpm_pkg::t_cfg                      i_cfg,
    input  logic                                i_q_empty,
    input  cbpm_pkg::t_item                     i_item,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [cbpm_pkg::STATUS_W-1:0]       o_status,
    output logic                                o_signal_valid,
    output logic [cbpm_pkg::POS_W-1:0]          o_pedal_position,
    output logic signed [cbpm_pkg::REGEN_OUT_W-1:0] o_regen_level
);
    import cbpm_pkg::*;

    t_back_state r_state, n_state;

    t_status                  r_status;
    logic [POS_W-1:0]         r_pos;
    logic [LEVEL_W-1:0]       r_rem, r_den;
    logic [POS_W-1:0]         r_num_lo;
    logic [DIV_CNT_W-1:0]     r_cnt;
    logic                     r_neg;
    logic [PROD_W-1:0]        r_prod;
    logic [SCALED_W-1:0]      r_scaled;

    logic                     r_out_valid;
    t_status                  r_out_status;
    logic [POS_W-1:0]         r_out_pos;
    logic [REGEN_OUT_W-1:0]   r_out_regen;

    // load decode
    logic signed [LEVEL_W:0]  w_diff, w_span;
    logic [LEVEL_W-1:0]       w_abs_diff, w_abs_span;
    logic [LEVEL_W+POS_W-1:0] w_num;
    logic                     w_same_sign;

    // divider step
    logic [LEVEL_W:0]         w_t1, w_r1, w_t2, w_r2;
    logic                     w_q1, w_q2;

    // regen
    logic signed [LEVEL_W-1:0] w_range;
    logic [REGEN_W-1:0]        w_abs_range;
    logic [PROD_W+RECIP_W-1:0] w_recip_prod;
    logic [REGEN_OUT_W-1:0]    w_scaled_ext, w_ten_min, w_regen;

    logic w_take, w_load_out;

    assign w_take     = (r_state == BK_IDLE) && !i_q_empty;
    assign o_pop      = w_take;
    assign w_load_out = (r_state == BK_DONE) && (!r_out_valid || i_ready);

    assign w_diff      = $signed({1'b0, i_item.raw}) - $signed({1'b0, i_cfg.min_level});
    assign w_span      = $signed({1'b0, i_cfg.max_level}) - $signed({1'b0, i_cfg.min_level});
    assign w_abs_diff  = w_diff[LEVEL_W] ? LEVEL_W'(-w_diff) : w_diff[LEVEL_W-1:0];
    assign w_abs_span  = w_span[LEVEL_W] ? LEVEL_W'(-w_span) : w_span[LEVEL_W-1:0];
    assign w_num       = (LEVEL_W + POS_W)'(w_abs_diff) * (LEVEL_W + POS_W)'(POS_FULL);
    assign w_same_sign = (w_diff != 0) && (w_diff[LEVEL_W] == w_span[LEVEL_W]);

    // two restoring steps; the partial remainder always stays below the divisor
    assign w_t1 = {r_rem, r_num_lo[POS_W-1]};
    assign w_q1 = w_t1 >= {1'b0, r_den};
    assign w_r1 = w_q1 ? (w_t1 - {1'b0, r_den}) : w_t1;
    assign w_t2 = {w_r1[LEVEL_W-1:0], r_num_lo[POS_W-2]};
    assign w_q2 = w_t2 >= {1'b0, r_den};
    assign w_r2 = w_q2 ? (w_t2 - {1'b0, r_den}) : w_t2;

    assign w_range      = $signed({1'b0, i_cfg.max_regen}) - $signed({1'b0, i_cfg.min_regen});
    assign w_abs_range  = w_range[LEVEL_W-1] ? REGEN_W'(-w_range) : w_range[REGEN_W-1:0];
    assign w_recip_prod = (PROD_W + RECIP_W)'(r_prod) * (PROD_W + RECIP_W)'(RECIP_100);

    assign w_scaled_ext = REGEN_OUT_W'(r_scaled);
    assign w_ten_min    = REGEN_OUT_W'(i_cfg.min_regen) * REGEN_OUT_W'(10);
    always_comb begin
        if (r_pos == '0) begin
            w_regen = '0;
        end else if (r_neg) begin
            w_regen = (-w_scaled_ext) - w_ten_min;
        end else begin
            w_regen = w_scaled_ext - w_ten_min;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (w_take) begin
                    if (i_item.status == ST_OK && i_cfg.max_level != '0 && w_span != 0
                        && w_same_sign && w_abs_diff < w_abs_span) begin
                        n_state = BK_DIV;
                    end else begin
                        n_state = BK_MUL;
                    end
                end
            end
            BK_DIV: begin
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = BK_MUL;
                end
            end
            BK_MUL:   n_state = BK_SCALE;
            BK_SCALE: n_state = BK_DONE;
            BK_DONE: begin
                if (w_load_out) begin
                    n_state = BK_IDLE;
                end
            end
            default:  n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            BK_IDLE: begin
                if (w_take) begin
                    r_status <= i_item.status;
                    r_cnt    <= '0;
                    r_rem    <= w_num[LEVEL_W+POS_W-1:POS_W];
                    r_num_lo <= w_num[POS_W-1:0];
                    r_den    <= w_abs_span;
                    priority if (i_item.status != ST_OK || i_cfg.max_level == '0) begin
                        r_pos <= '0;
                    end else if (w_span == 0) begin
                        r_pos <= (i_item.raw > i_cfg.max_level) ? POS_FULL : '0;
                    end else if (!w_same_sign) begin
                        r_pos <= '0;
                    end else if (w_abs_diff >= w_abs_span) begin
                        r_pos <= POS_FULL;
                    end else begin
                        r_pos <= '0;
                    end
                end
            end
            BK_DIV: begin
                r_rem    <= w_r2[LEVEL_W-1:0];
                r_num_lo <= {r_num_lo[POS_W-3:0], 2'b00};
                r_pos    <= {r_pos[POS_W-3:0], w_q1, w_q2};
                r_cnt    <= r_cnt + 1'b1;
            end
            BK_MUL: begin
                r_neg  <= !w_range[LEVEL_W-1] && (w_range != 0);
                r_prod <= PROD_W'(w_abs_range) * PROD_W'(r_pos);
            end
            BK_SCALE: begin
                r_scaled <= w_recip_prod[RECIP_SHIFT +: SCALED_W];
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    // output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_status <= r_status;
            r_out_pos    <= r_pos;
            r_out_regen  <= w_regen;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_signal_valid   = (r_out_status == ST_OK);
    assign o_pedal_position = r_out_pos;
    assign o_regen_level    = $signed(r_out_regen);

endmodule

// ===== tb/sv/tb_can_brake_pedal_monitor.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for can_brake_pedal_monitor: directed table, then random
// register settings and CAN frame / tick traffic against an in-bench predictor.
// Depends on cbpm_pkg and the can_brake_pedal_monitor RTL only.
module tb_can_brake_pedal_monitor;
    import cbpm_pkg::*;

    localparam logic                 ACT_FRAME   = 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 3'd7;
    localparam int                   BLOCKS      = 17;
    localparam int                   BLOCK_ITEMS = 50;
    localparam int                   DRAIN_GAP   = 20;
    localparam int                   MAX_PRINTS  = 40;

    typedef struct packed {
        logic [STATUS_W-1:0]    st;
        logic                   vld;
        logic [POS_W-1:0]       pos;
        logic [REGEN_OUT_W-1:0] regen;
    } t_pedal_res;

    typedef struct {
        bit                    is_write;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] wdata;
        logic                  act;
        logic [ID_W-1:0]       fid;
        logic [LEVEL_W-1:0]    pbyte;
        bit                    pinned;
        t_status               st;
        int                    pos;
        int                    regen;
    } t_dir_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [S_TDATA_W-1:0]    s_axis_tdata = '0;   // frame_id, position_byte
    logic                    s_axis_tuser = 1'b0; // action
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // status, signal_valid, pedal_position, regen_level
    logic [M_TDATA_W-1:0]    m_axis_tdata;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;

    can_brake_pedal_monitor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // shadow registers and state of the pedal monitor
    logic [ID_W-1:0]    shadow_resp_id;
    logic [LEVEL_W-1:0] shadow_min_lv, shadow_max_lv, shadow_tol, shadow_max_lost;
    logic [REGEN_W-1:0] shadow_min_rg, shadow_max_rg;
    logic [LOST_W-1:0]  lost_cnt;
    logic [LEVEL_W-1:0] raw_level;

    t_pedal_res pending_results[$];
    bit         row_pinned = 1'b0;
    t_pedal_res row_want;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int n_errors    = 0;
    int n_items     = 0;
    int n_results   = 0;
    int n_settings  = 0;
    int n_status[4] = '{0, 0, 0, 0};

    function automatic t_pedal_res predict_pedal(input logic act, input logic [ID_W-1:0] fid,
                                                 input logic [LEVEL_W-1:0] pbyte);
        t_pedal_res r;
        t_status    st;
        int         raw, lo, hi, p, rg;
        if (act == ACT_TICK) begin
            if (lost_cnt < LOST_COUNT_MAX)
                lost_cnt = lost_cnt + 1'b1;
        end else if (fid == shadow_resp_id) begin
            raw_level = pbyte;
            lost_cnt  = '0;
        end
        raw = int'(raw_level);
        lo  = int'(shadow_min_lv);
        hi  = int'(shadow_max_lv);
        if (lost_cnt >= shadow_max_lost)
            st = ST_LOST;
        else if (raw > hi + int'(shadow_tol))
            st = ST_HIGH;
        else if (raw < lo - int'(shadow_tol))
            st = ST_LOW;
        else
            st = ST_OK;
        p  = 0;
        rg = 0;
        if (st == ST_OK) begin
            if (shadow_max_lv == '0)
                p = 0;
            else if (hi == lo)
                p = (raw > hi) ? 1000 : 0;
            else begin
                // signed, truncating toward zero, then clamp
                p = (raw - lo) * 1000 / (hi - lo);
                if (p < 0)
                    p = 0;
                if (p > 1000)
                    p = 1000;
            end
            if (p != 0)
                rg = (-10 * (int'(shadow_max_rg) - int'(shadow_min_rg)) * p) / 1000
                     - 10 * int'(shadow_min_rg);
        end
        r.st    = st;
        r.vld   = (st == ST_OK);
        r.pos   = p[POS_W-1:0];
        r.regen = rg[REGEN_OUT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (n_errors < MAX_PRINTS)
            $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        n_errors++;
    endtask

    // Check the result side first so that a stray result cannot claim the
    // expectation pushed at the same edge.
    always @(posedge i_clk) begin
        t_pedal_res got, want;
        if (!i_rst_n) begin
            shadow_resp_id  = ID_W'(1896);
            shadow_min_lv   = '0;
            shadow_max_lv   = '0;
            shadow_tol      = LEVEL_W'(10);
            shadow_max_lost = LEVEL_W'(3);
            shadow_min_rg   = '0;
            shadow_max_rg   = REGEN_W'(50);
            lost_cnt        = LOST_W'(LOST_COUNT_MAX);
            raw_level       = '0;
            pending_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_RESPONSE_ID: shadow_resp_id  = i_cfg_data[ID_W-1:0];
                    REG_MIN_LEVEL:   shadow_min_lv   = i_cfg_data[LEVEL_W-1:0];
                    REG_MAX_LEVEL:   shadow_max_lv   = i_cfg_data[LEVEL_W-1:0];
                    REG_TOLERANCE:   shadow_tol      = i_cfg_data[LEVEL_W-1:0];
                    REG_MAX_LOST:    shadow_max_lost = i_cfg_data[LEVEL_W-1:0];
                    REG_MIN_REGEN:   shadow_min_rg   = i_cfg_data[REGEN_W-1:0];
                    REG_MAX_REGEN:   shadow_max_rg   = i_cfg_data[REGEN_W-1:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.st    = m_axis_tdata[1:0];
                got.vld   = m_axis_tdata[2];
                got.pos   = m_axis_tdata[12:3];
                got.regen = m_axis_tdata[24:13];
                n_results++;
                n_status[got.st]++;
                if (pending_results.size() == 0) begin
                    report_mismatch("result with nothing pending (status)", int'(got.st), -1);
                end else begin
                    want = pending_results.pop_front();
                    if (got.st != want.st)
                        report_mismatch("status", int'(got.st), int'(want.st));
                    if (got.vld != want.vld)
                        report_mismatch("signal_valid", int'(got.vld), int'(want.vld));
                    if (got.pos != want.pos)
                        report_mismatch("pedal_position", int'(got.pos), int'(want.pos));
                    if (got.regen != want.regen)
                        report_mismatch("regen_level", int'($signed(got.regen)),
                                        int'($signed(want.regen)));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                want = predict_pedal(s_axis_tuser, s_axis_tdata[ID_W-1:0],
                                     s_axis_tdata[ID_W+LEVEL_W-1:ID_W]);
                if (row_pinned)
                    want = row_want;
                pending_results.push_back(want);
                n_items++;
            end
        end
    end

    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

    task automatic send_item(input logic act, input logic [ID_W-1:0] fid,
                             input logic [LEVEL_W-1:0] pbyte);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= S_TDATA_W'({pbyte, fid});
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Hold the input until every pending result is back, then let the back end settle.
    task automatic wait_results_drained;
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_GAP) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic t_dir_row cfg_row(input logic [CFG_IDX_W-1:0] idx, input int val);
        t_dir_row r;
        r = '{st: ST_OK, default: 0};
        r.is_write = 1'b1;
        r.idx      = idx;
        r.wdata    = CFG_DATA_W'(val);
        return r;
    endfunction

    function automatic t_dir_row in_row(input logic act, input int fid, input int pbyte,
                                        input bit pin, input t_status st, input int pos,
                                        input int rg);
        t_dir_row r;
        r = '{st: ST_OK, default: 0};
        r.act    = act;
        r.fid    = ID_W'(fid);
        r.pbyte  = LEVEL_W'(pbyte);
        r.pinned = pin;
        r.st     = st;
        r.pos    = pos;
        r.regen  = rg;
        return r;
    endfunction

    initial begin
        t_dir_row plan[$];
        int       cfg_val[7];
        int       cur_id, cur_min, cur_max, cur_tol, lo_b, hi_b, sel;
        logic     act;
        logic [ID_W-1:0]    fid;
        logic [LEVEL_W-1:0] pbyte;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        plan = '{
            // defaults: response lost until the first matching frame, brake disabled
            in_row(ACT_TICK,  0,    0,   1, ST_LOST, 0, 0),
            in_row(ACT_FRAME, 1896, 0,   1, ST_OK,   0, 0),
            in_row(ACT_FRAME, 1896, 255, 1, ST_HIGH, 0, 0),
            in_row(ACT_FRAME, 1897, 0,   1, ST_HIGH, 0, 0),
            in_row(ACT_FRAME, 1896, 10,  1, ST_OK,   0, 0),
            in_row(ACT_TICK,  0,    0,   1, ST_OK,   0, 0),
            in_row(ACT_TICK,  0,    0,   1, ST_OK,   0, 0),
            in_row(ACT_TICK,  0,    0,   1, ST_LOST, 0, 0),
            cfg_row(REG_MIN_LEVEL, 20),
            cfg_row(REG_MAX_LEVEL, 220),
            cfg_row(REG_TOLERANCE, 0),
            cfg_row(REG_MAX_LOST, 255),
            cfg_row(REG_MIN_REGEN, 0),
            cfg_row(REG_MAX_REGEN, 100),
            in_row(ACT_FRAME, 1896, 20,  1, ST_OK,   0,    0),
            in_row(ACT_FRAME, 1896, 220, 1, ST_OK,   1000, -1000),
            in_row(ACT_FRAME, 1896, 221, 1, ST_HIGH, 0,    0),
            in_row(ACT_FRAME, 1896, 19,  1, ST_LOW,  0,    0),
            in_row(ACT_FRAME, 1896, 120, 0, ST_OK,   0,    0),
            in_row(ACT_FRAME, 1896, 77,  0, ST_OK,   0,    0),
            // equal limits, regen registers beyond 100, unused index ignored
            cfg_row(REG_RESPONSE_ID, 0),
            cfg_row(REG_MIN_LEVEL, 100),
            cfg_row(REG_MAX_LEVEL, 100),
            cfg_row(REG_TOLERANCE, 255),
            cfg_row(REG_MIN_REGEN, 127),
            cfg_row(REG_MAX_REGEN, 127),
            cfg_row(REG_UNUSED, 29'h1FFF_FFFF),
            in_row(ACT_FRAME, 0, 101, 1, ST_OK, 1000, -1270),
            in_row(ACT_FRAME, 0, 100, 1, ST_OK, 0,    0),
            in_row(ACT_FRAME, 0, 0,   1, ST_OK, 0,    0),
            // inverted limits
            cfg_row(REG_MIN_LEVEL, 200),
            cfg_row(REG_MAX_LEVEL, 50),
            cfg_row(REG_MIN_REGEN, 0),
            in_row(ACT_FRAME, 0, 100, 0, ST_OK, 0, 0),
            in_row(ACT_FRAME, 0, 250, 1, ST_OK, 0, 0),
            // regen falling with pedal travel
            cfg_row(REG_MIN_LEVEL, 0),
            cfg_row(REG_MAX_LEVEL, 255),
            cfg_row(REG_MIN_REGEN, 127),
            cfg_row(REG_MAX_REGEN, 0),
            in_row(ACT_FRAME, 0, 255, 0, ST_OK, 0, 0),
            in_row(ACT_FRAME, 0, 128, 0, ST_OK, 0, 0),
            // zero loss limit: always lost
            cfg_row(REG_RESPONSE_ID, 29'h1FFF_FFFF),
            cfg_row(REG_MAX_LOST, 0),
            in_row(ACT_FRAME, 29'h1FFF_FFFF, 200, 1, ST_LOST, 0, 0),
            in_row(ACT_TICK,  29'h1FFF_FFFF, 255, 1, ST_LOST, 0, 0),
            in_row(ACT_FRAME, 29'h1FFF_FFFE, 5,   1, ST_LOST, 0, 0)
        };

        tx_idle_pct = 38;
        rx_idle_pct = 73;
        foreach (plan[i]) begin
            if (plan[i].is_write) begin
                if (i > 0 && !plan[i-1].is_write) begin
                    wait_results_drained();
                    n_settings++;
                end
                write_reg(plan[i].idx, plan[i].wdata);
            end else begin
                row_pinned     = plan[i].pinned;
                row_want.st    = plan[i].st;
                row_want.vld   = (plan[i].st == ST_OK);
                row_want.pos   = POS_W'(plan[i].pos);
                row_want.regen = REGEN_OUT_W'(plan[i].regen);
                send_item(plan[i].act, plan[i].fid, plan[i].pbyte);
            end
        end
        row_pinned = 1'b0;

        for (int b = 0; b < BLOCKS; b++) begin
            wait_results_drained();
            case (b)
                0: cfg_val = '{29'h1FFF_FFFF, 255, 255, 255, 255, 127, 127};
                1: cfg_val = '{0, 0, 0, 0, 1, 0, 0};
                2: cfg_val = '{int'($urandom_range(0, 2047)), 10, 200, 5, 0, 20, 80};
                default: begin
                    cfg_val[REG_RESPONSE_ID] = int'(ID_W'($urandom));
                    cfg_val[REG_MIN_LEVEL]   = $urandom_range(0, 160);
                    cfg_val[REG_MAX_LEVEL]   = ($urandom_range(0, 4) != 0)
                                             ? $urandom_range(cfg_val[REG_MIN_LEVEL], 255)
                                             : $urandom_range(0, 255);
                    cfg_val[REG_TOLERANCE]   = ($urandom_range(0, 9) < 7)
                                             ? $urandom_range(0, 15) : $urandom_range(0, 255);
                    cfg_val[REG_MAX_LOST]    = ($urandom_range(0, 19) < 17)
                                             ? $urandom_range(1, 8) : $urandom_range(0, 255);
                    cfg_val[REG_MIN_REGEN]   = ($urandom_range(0, 4) != 0)
                                             ? $urandom_range(0, 100) : $urandom_range(0, 127);
                    cfg_val[REG_MAX_REGEN]   = ($urandom_range(0, 4) != 0)
                                             ? $urandom_range(0, 100) : $urandom_range(0, 127);
                end
            endcase
            for (int r = 0; r < 7; r++)
                write_reg(CFG_IDX_W'(r), CFG_DATA_W'(cfg_val[r]));
            n_settings++;
            cur_id  = cfg_val[REG_RESPONSE_ID];
            cur_min = cfg_val[REG_MIN_LEVEL];
            cur_max = cfg_val[REG_MAX_LEVEL];
            cur_tol = cfg_val[REG_TOLERANCE];
            // aim readings at the band edges most of the time
            lo_b = ((cur_min < cur_max) ? cur_min : cur_max) - cur_tol - 2;
            hi_b = ((cur_min > cur_max) ? cur_min : cur_max) + cur_tol + 2;
            if (lo_b < 0)
                lo_b = 0;
            if (hi_b > 255)
                hi_b = 255;

            if (b < 6) begin
                tx_idle_pct = 38;
                rx_idle_pct = 73;
            end else if (b < 12) begin
                tx_idle_pct = 73;
                rx_idle_pct = 38;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            repeat (BLOCK_ITEMS) begin
                sel   = $urandom_range(0, 99);
                act   = (sel < 25) ? ACT_TICK : ACT_FRAME;
                pbyte = ($urandom_range(0, 2) == 0) ? LEVEL_W'($urandom_range(0, 255))
                                                    : LEVEL_W'($urandom_range(lo_b, hi_b));
                if (sel < 25 || sel >= 93)
                    fid = ID_W'($urandom);
                else if (sel < 86)
                    fid = ID_W'(cur_id);
                else
                    fid = ID_W'(cur_id) ^ (ID_W'(1) << $urandom_range(0, ID_W - 1));
                send_item(act, fid, pbyte);
            end
        end

        wait_results_drained();
        $display("%0d transactions in, %0d results checked, %0d register settings",
                 n_items, n_results, n_settings);
        $display("status mix: ok %0d, lost %0d, too high %0d, too low %0d",
                 n_status[ST_OK], n_status[ST_LOST], n_status[ST_HIGH], n_status[ST_LOW]);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
